// File: rtl/lcd_pixel_window_writer_assert.svh
// Assertion macros for the LCD pixel window writer checker.
// Depends on nothing; included by the checker file only.
`ifndef LCD_PIXEL_WINDOW_WRITER_ASSERT_SVH
`define LCD_PIXEL_WINDOW_WRITER_ASSERT_SVH

// Clocked assertion with reset disable.
`define LPWW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion without reset disable, so it is checked during reset as well.
`define LPWW_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/lcdpw_pkg.sv
// Shared types, constants and the byte generator for the LCD pixel window writer.
// No dependencies.
package lcdpw_pkg;

   localparam int PANEL_LONG    = 220;
   localparam int PANEL_SHORT   = 128;
   localparam int WINDOW_OFFSET = 24;

   localparam int COORD_W    = 16;
   localparam int COLOR_W    = 16;
   localparam int BYTE_COUNT = 19;
   localparam int POS_W      = $clog2(BYTE_COUNT);
   localparam int FIFO_DEPTH = 2;

   // Command and data codes on the link
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h03;
   localparam logic [7:0] ENTRY_MODE_HI  = 8'h12;
   localparam logic [7:0] MODE_ORIENT0   = 8'h08;
   localparam logic [7:0] MODE_ORIENT1   = 8'h38;
   localparam logic [7:0] MODE_ORIENT2   = 8'h20;
   localparam logic [7:0] MODE_ORIENT3   = 8'h10;
   localparam logic [7:0] CMD_HWIN_END   = 8'h37;
   localparam logic [7:0] CMD_HWIN_START = 8'h36;
   localparam logic [7:0] CMD_VWIN_END   = 8'h39;
   localparam logic [7:0] CMD_VWIN_START = 8'h38;
   localparam logic [7:0] CMD_MEM_WRITE  = 8'h22;

   typedef struct packed {
      logic [1:0]         orient;
      logic [COORD_W-1:0] win_a;  // value for the first two window commands
      logic [COORD_W-1:0] win_b;  // value for the last two
      logic [COLOR_W-1:0] color;
   } pixel_rec_type;

   typedef struct packed {
      logic [7:0] link_byte;
      logic       is_data;
      logic       frame_end;
      logic       last_byte;
   } link_out_type;

   function automatic logic [7:0] mode_byte(input logic [1:0] o);
      logic [7:0] m;
      case (o)
         2'd0:    m = MODE_ORIENT0;
         2'd1:    m = MODE_ORIENT1;
         2'd2:    m = MODE_ORIENT2;
         default: m = MODE_ORIENT3;
      endcase
      return m;
   endfunction

   // 5-bit channel to the 8-bit link form of its 6-bit widening
   function automatic logic [7:0] widen5(input logic [4:0] c);
      return {c, c[4], 2'b00};
   endfunction

   // Byte at position pos of the sequence for one pixel
   function automatic link_out_type gen_byte(input logic [POS_W-1:0] pos,
                                             input pixel_rec_type rec);
      link_out_type r;
      logic         swap;
      swap        = rec.orient[1];
      r.is_data   = 1'b1;
      r.frame_end = 1'b1;
      r.last_byte = 1'b0;
      r.link_byte = 8'h00;
      case (pos)
         5'd0: begin
            r.link_byte = CMD_ENTRY_MODE;
            r.is_data   = 1'b0;
         end
         5'd1:  r.link_byte = ENTRY_MODE_HI;
         5'd2:  r.link_byte = mode_byte(rec.orient);
         5'd3: begin
            r.link_byte = swap ? CMD_VWIN_END : CMD_HWIN_END;
            r.is_data   = 1'b0;
         end
         5'd4, 5'd7:   r.link_byte = rec.win_a[15:8];
         5'd5, 5'd8:   r.link_byte = rec.win_a[7:0];
         5'd6: begin
            r.link_byte = swap ? CMD_VWIN_START : CMD_HWIN_START;
            r.is_data   = 1'b0;
         end
         5'd9: begin
            r.link_byte = swap ? CMD_HWIN_END : CMD_VWIN_END;
            r.is_data   = 1'b0;
         end
         5'd10, 5'd13: r.link_byte = rec.win_b[15:8];
         5'd11, 5'd14: r.link_byte = rec.win_b[7:0];
         5'd12: begin
            r.link_byte = swap ? CMD_HWIN_START : CMD_VWIN_START;
            r.is_data   = 1'b0;
         end
         5'd15: begin
            r.link_byte = CMD_MEM_WRITE;
            r.is_data   = 1'b0;
         end
         5'd16: begin
            r.link_byte = widen5(rec.color[15:11]);
            r.frame_end = 1'b0;
         end
         5'd17: begin
            r.link_byte = {rec.color[10:5], 2'b00};
            r.frame_end = 1'b0;
         end
         5'd18: begin
            r.link_byte = widen5(rec.color[4:0]);
            r.last_byte = 1'b1;
         end
         default: r.link_byte = 8'h00;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/lcd_pixel_window_writer.sv
// LCD pixel window writer: one pixel request in, 19 serial-link bytes out.
// The request is written into the queue, then its first byte into the output register
// that drives rsp. The back-end byte sequencer sends one byte per cycle while rsp_tready
// allows; an off-panel request is taken, when the queue has room, with no output.
// Reset (synchronous, active high) clears orientation to 0, empties the queue
// and drops any byte in the output register.
module lcd_pixel_window_writer
   import lcdpw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // pixel_x [15:0], pixel_y [31:16], pixel_color [47:32]
   // link byte channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // link_byte [7:0]
   output logic [1:0]  rsp_tuser,  // is_data [0], frame_end [1]
   output logic        rsp_tlast,  // last_byte of the pixel
   // orientation register
   input  logic        csr_wen,
   input  logic [1:0]  csr_wdata
);

   // front -> queue
   logic          push_valid, push_ready;
   pixel_rec_type push_rec;
   // queue -> back
   logic          head_valid, pop;
   pixel_rec_type head_rec;

   // Front: bounds check, window values, orientation captured per request
   lcdpw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .push_ready (push_ready)
   );

   // Two entries: the front may take the next request while the back is
   // still sending the current one
   lcdpw_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop)
   );

   // Back: byte sequencer, pops the head as its last byte is registered
   lcdpw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/lcdpw_front.sv
// Front end: orientation register, panel bounds check and window value setup.
// Depends on lcdpw_pkg.
module lcdpw_front
   import lcdpw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [47:0]   req_tdata,
   input  logic          csr_wen,
   input  logic [1:0]    csr_wdata,
   output logic          push_valid,
   output pixel_rec_type push_rec,
   input  logic          push_ready
);

   logic [1:0]         orient_ff, orient_in;
   logic [COORD_W-1:0] x, y, w, h;
   logic               in_panel;

   assign orient_in = csr_wen ? csr_wdata : orient_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff <= 2'd0;
      end else begin
         orient_ff <= orient_in;
      end
   end

   assign x = req_tdata[15:0];
   assign y = req_tdata[31:16];
   assign w = orient_ff[0] ? COORD_W'(PANEL_SHORT) : COORD_W'(PANEL_LONG);
   assign h = orient_ff[0] ? COORD_W'(PANEL_LONG)  : COORD_W'(PANEL_SHORT);

   // sign bit set means negative, so off panel
   assign in_panel = !x[COORD_W-1] && !y[COORD_W-1] && (x < w) && (y < h);

   always_comb begin
      push_rec.orient = orient_ff;
      push_rec.color  = req_tdata[47:32];
      if (orient_ff[1]) begin
         push_rec.win_a = x;
         push_rec.win_b = y + COORD_W'(WINDOW_OFFSET);
      end else begin
         push_rec.win_a = x + COORD_W'(WINDOW_OFFSET);
         push_rec.win_b = y;
      end
   end

   // off-panel requests are taken and dropped here
   assign req_tready = push_ready;
   assign push_valid = req_tvalid && in_panel;

endmodule

// File: rtl/lcdpw_fifo.sv
// Two-entry pixel queue between front and back ends.
// Depends on lcdpw_pkg.
module lcdpw_fifo
   import lcdpw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  pixel_rec_type push_rec,
   output logic          push_ready,
   output logic          head_valid,
   output pixel_rec_type head_rec,
   input  logic          pop
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   pixel_rec_type      store_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_rec   = store_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// File: rtl/lcdpw_back.sv
// Back end: steps through the 19 link bytes of the head pixel into the output register.
// Depends on lcdpw_pkg.
module lcdpw_back
   import lcdpw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  pixel_rec_type head_rec,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             valid_ff, valid_in;
   link_out_type     out_ff, out_in;
   logic             advance, emit, at_end;

   assign advance = !valid_ff || rsp_tready;
   assign emit    = advance && head_valid;
   assign at_end  = (pos_ff == POS_W'(BYTE_COUNT - 1));
   assign pop     = emit && at_end;

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (advance) begin
         valid_in = head_valid;
         if (head_valid) begin
            out_in = gen_byte(pos_ff, head_rec);
            pos_in = at_end ? '0 : pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = out_ff.link_byte;
   assign rsp_tuser  = {out_ff.frame_end, out_ff.is_data};
   assign rsp_tlast  = out_ff.last_byte;

endmodule

// File: rtl/lcdpw_checker.sv
// Port-level checker for the LCD pixel window writer, bound to the top level.
// Depends on lcdpw_pkg and lcd_pixel_window_writer_assert.svh.
`include "lcd_pixel_window_writer_assert.svh"

module lcdpw_checker
   import lcdpw_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // position of the current byte within its pixel, from accepted bytes
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_take;
   logic             first_ok, last_ok, end_ok;

   assign rsp_take = rsp_tvalid && rsp_tready;

   always_comb begin
      pos_in = pos_ff;
      if (rsp_take) begin
         pos_in = rsp_tlast ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   assign first_ok = (pos_ff != '0) || ((rsp_tdata == CMD_ENTRY_MODE) && !rsp_tuser[0]);
   assign last_ok  = rsp_tlast == (pos_ff == POS_W'(BYTE_COUNT - 1));
   assign end_ok   = rsp_tuser[1] || (pos_ff == POS_W'(BYTE_COUNT - 3))
                     || (pos_ff == POS_W'(BYTE_COUNT - 2));

   `LPWW_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped while stalled")
   `LPWW_ASSERT(a_first_cmd, rsp_tvalid |-> first_ok, "pixel does not open with entry mode")
   `LPWW_ASSERT(a_last_pos, rsp_tvalid |-> last_ok, "tlast not on the 19th byte")
   `LPWW_ASSERT(a_frame_end, rsp_tvalid |-> end_ok, "frame held open outside colour bytes")
   `LPWW_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "rsp valid after reset")

endmodule

bind lcd_pixel_window_writer lcdpw_checker u_checker (.*);
